FILE: rtl/core/bfsf_pkg.sv
// bfsf_pkg: shared widths, opcodes, status codes and the word unit result type
// for the bitmap free slot finder; no dependencies
package bfsf_pkg;

   localparam int CSR_W  = 6;
   localparam int OP_W   = 3;
   localparam int IDX_W  = 10;
   localparam int BIT_W  = 5;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;

   localparam logic [WORD_W-1:0] FULL_WORD = 32'hFFFF_FFFF;

   localparam logic [OP_W-1:0] OP_SET    = 3'd0;
   localparam logic [OP_W-1:0] OP_UNSET  = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

   typedef struct packed {
      logic [WORD_W-1:0] new_word;
      logic              new_full;
      logic              bit_val;
      logic              has_zero;
      logic [BIT_W-1:0]  zero_pos;
   } wu_res_type;

endpackage

FILE: rtl/core/bfsf_if.sv
// bfsf_req_if and bfsf_rsp_if: valid/ready channels of the bitmap free slot finder
// depends on bfsf_pkg for field widths
interface bfsf_req_if;
   import bfsf_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [IDX_W-1:0]    bit_index;
   modport source (output valid, op, bit_index, input ready);
   modport sink (input valid, op, bit_index, output ready);
endinterface

interface bfsf_rsp_if;
   import bfsf_pkg::*;
   logic                valid;
   logic                ready;
   logic [STAT_W-1:0]   status;
   logic                bit_value;
   logic [IDX_W-1:0]    found_index;
   modport source (output valid, status, bit_value, found_index, input ready);
   modport sink (input valid, status, bit_value, found_index, output ready);
endinterface

FILE: rtl/core/bfsf_mem.sv
// bfsf_mem: bitmap word store, one write port and one registered read port
// depends on bfsf_pkg for the word width
module bfsf_mem #(
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bfsf_pkg::WORD_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bfsf_pkg::WORD_W-1:0] rd_data
);
   import bfsf_pkg::*;

   logic [WORD_W-1:0] words_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= words_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bfsf_word_unit.sv
// bfsf_word_unit: shared word datapath: bit update, bit read, full test and
// lowest clear bit search over one 32-bit word; depends on bfsf_pkg
module bfsf_word_unit (
   input  logic [bfsf_pkg::WORD_W-1:0] word,
   input  logic [bfsf_pkg::OP_W-1:0]   op,
   input  logic [bfsf_pkg::BIT_W-1:0]  bit_pos,
   output bfsf_pkg::wu_res_type        res
);
   import bfsf_pkg::*;

   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] upd;
   logic [BIT_W-1:0]  pos;

   always_comb begin
      mask = WORD_W'(1) << bit_pos;
      case (op)
         OP_SET:   upd = word | mask;
         OP_UNSET: upd = word & ~mask;
         default:  upd = word;
      endcase
      // walk down so the lowest clear bit wins
      pos = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (!word[j]) begin
            pos = BIT_W'(j);
         end
      end
      res.new_word = upd;
      res.new_full = (upd == FULL_WORD);
      res.bit_val  = word[bit_pos];
      res.has_zero = (word != FULL_WORD);
      res.zero_pos = pos;
   end

endmodule

FILE: rtl/core/bfsf_ctrl.sv
// bfsf_ctrl: sequencer, word count register, anchor, clean mark and result register
// depends on bfsf_pkg and the bfsf_req_if / bfsf_rsp_if channels
module bfsf_ctrl #(
   parameter int  WORDS = 32,
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   bfsf_req_if.sink                    req_ch,
   bfsf_rsp_if.source                  rsp_ch,
   input  logic                        csr_we,
   input  logic [bfsf_pkg::CSR_W-1:0]  csr_wdata,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [bfsf_pkg::WORD_W-1:0] mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [bfsf_pkg::WORD_W-1:0] mem_rd_data,
   output logic [bfsf_pkg::WORD_W-1:0] wu_word,
   output logic [bfsf_pkg::OP_W-1:0]   wu_op,
   output logic [bfsf_pkg::BIT_W-1:0]  wu_bit,
   input  bfsf_pkg::wu_res_type        wu_res
);
   import bfsf_pkg::*;

   localparam int CW     = $clog2(WORDS + 1);
   localparam int XW     = (CW > BIT_W) ? CW : BIT_W;
   localparam int CMPW   = (CW > CSR_W) ? CW : CSR_W;
   localparam int RST_WC = (WORDS < 32) ? WORDS : 32;

   typedef enum logic [2:0] {S_IDLE, S_EVAL, S_FILL, S_SCAN, S_RESP} state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [CW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      word_count_ff, word_count_in;
   logic [CW-1:0]      mark_ff, mark_in;
   logic [CW-1:0]      anchor_ff, anchor_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [WORD_W-1:0]  new_word_ff, new_word_in;
   logic               full_ff, full_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic               res_bit_ff, res_bit_in;
   logic [IDX_W-1:0]   res_found_ff, res_found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic               rsp_bit_ff, rsp_bit_in;
   logic [IDX_W-1:0]   rsp_found_ff, rsp_found_in;

   logic [XW-1:0]      word_x;
   logic               in_range;
   logic               rd_zero;
   logic [XW-1:0]      addr_x;
   logic               upd_full;
   logic [CW-1:0]      anchor_wr;
   logic [CMPW-1:0]    csr_val;
   logic [CMPW-1:0]    csr_lim;

   assign word_x   = XW'(req_ch.bit_index[IDX_W-1:BIT_W]);
   assign in_range = word_x < XW'(word_count_ff);
   // words at or above the clean mark are logically zero
   assign rd_zero  = addr_ff >= mark_ff;
   assign addr_x   = XW'(addr_ff);
   assign wu_word  = rd_zero ? '0 : mem_rd_data;
   assign wu_op    = op_ff;
   assign wu_bit   = bit_ff;
   assign upd_full = (state_ff == S_EVAL) ? wu_res.new_full : full_ff;
   assign csr_val  = CMPW'(csr_wdata);
   assign csr_lim  = (csr_val > CMPW'(WORDS)) ? CMPW'(WORDS) : csr_val;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.bit_value   = rsp_bit_ff;
   assign rsp_ch.found_index = rsp_found_ff;

   // anchor after a set or unset lands on word addr_ff
   always_comb begin
      anchor_wr = anchor_ff;
      if (op_ff == OP_SET) begin
         if (addr_ff == anchor_ff && upd_full) begin
            anchor_wr = anchor_ff + 1'b1;
         end
      end else if (addr_ff <= anchor_ff) begin
         anchor_wr = addr_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      word_count_in = word_count_ff;
      mark_in       = mark_ff;
      anchor_in     = anchor_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      new_word_in   = new_word_ff;
      full_in       = full_ff;
      res_status_in = res_status_ff;
      res_bit_in    = res_bit_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_found_in  = rsp_found_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.op;
               bit_in        = req_ch.bit_index[BIT_W-1:0];
               addr_in       = CW'(word_x);
               res_status_in = STAT_OK;
               res_bit_in    = 1'b0;
               res_found_in  = '0;
               unique case (req_ch.op) inside
                  OP_SET, OP_UNSET, OP_GET: begin
                     if (!in_range) begin
                        res_status_in = STAT_RANGE;
                        state_in      = S_RESP;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = word_x[AW-1:0];
                        state_in    = S_EVAL;
                     end
                  end
                  OP_SEARCH: begin
                     ptr_in   = anchor_ff;
                     pend_in  = 1'b0;
                     state_in = S_SCAN;
                  end
                  OP_CLEAR: begin
                     mark_in   = '0;
                     anchor_in = '0;
                     state_in  = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (op_ff == OP_GET) begin
               res_bit_in = wu_res.bit_val;
               state_in   = S_RESP;
            end else begin
               new_word_in = wu_res.new_word;
               full_in     = wu_res.new_full;
               if (!rd_zero) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = addr_ff[AW-1:0];
                  mem_wr_data = wu_res.new_word;
                  anchor_in   = anchor_wr;
                  state_in    = S_RESP;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            // zero the words between the clean mark and the target first
            mem_wr_en = 1'b1;
            if (mark_ff == addr_ff) begin
               mem_wr_addr = addr_ff[AW-1:0];
               mem_wr_data = new_word_ff;
               mark_in     = addr_ff + 1'b1;
               anchor_in   = anchor_wr;
               state_in    = S_RESP;
            end else begin
               mem_wr_addr = mark_ff[AW-1:0];
               mem_wr_data = '0;
               mark_in     = mark_ff + 1'b1;
            end
         end
         S_SCAN: begin
            // check the word read last cycle while reading the next one
            if (pend_ff && wu_res.has_zero) begin
               anchor_in    = addr_ff;
               res_found_in = {addr_x[IDX_W-BIT_W-1:0], wu_res.zero_pos};
               state_in     = S_RESP;
            end else if (ptr_ff >= word_count_ff) begin
               res_status_in = STAT_NONE;
               state_in      = S_RESP;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff[AW-1:0];
               addr_in     = ptr_ff;
               pend_in     = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bit_in    = res_bit_ff;
               rsp_found_in  = res_found_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // growing the word count: newly included words read as zero
      if (csr_we) begin
         word_count_in = CW'(csr_lim);
         if (csr_lim > CMPW'(word_count_ff) && mark_in > word_count_ff) begin
            mark_in = word_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bit_ff        <= bit_in;
      addr_ff       <= addr_in;
      ptr_ff        <= ptr_in;
      new_word_ff   <= new_word_in;
      full_ff       <= full_in;
      res_status_ff <= res_status_in;
      res_bit_ff    <= res_bit_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bit_ff    <= rsp_bit_in;
      rsp_found_ff  <= rsp_found_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         word_count_ff <= CW'(RST_WC);
         mark_ff       <= '0;
         anchor_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         mark_ff       <= mark_in;
         anchor_ff     <= anchor_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_clear_resets: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == OP_CLEAR)
      |=> (anchor_ff == '0 && mark_ff == '0))
      else $error("clear transaction did not reset anchor and clean mark");

   a_write_below_mark: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> (mark_ff > CW'($past(mem_wr_addr))))
      else $error("word written at or above the clean mark");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK)
      |-> (rsp_found_ff == '0 && rsp_bit_ff == 1'b0))
      else $error("failed transaction carries nonzero data");
`endif

endmodule

FILE: rtl/core/bitmap_free_slot_finder.sv
// bitmap_free_slot_finder: bitmap allocator with first clear bit search
// depends on bfsf_pkg, bfsf_if, bfsf_mem, bfsf_word_unit and bfsf_ctrl
//
// req_ch carries one operation per transaction (op, bit_index); rsp_ch returns
// exactly one result per request (status, bit_value, found_index) in order.
// csr_we/csr_wdata write the word count; it saturates at WORDS and words that
// come back into use read as zero.
// req_ch.ready is high only while the sequencer is idle; one request is
// processed at a time, and a new one is taken while the last result waits.
// Clear, unused opcodes and out of range requests go straight to the
// response step; get and set/unset first read the target word, and a set or
// unset whose target still reads as zero zeroes the words from the clean
// mark up to the target before writing it. Search reads one word per cycle
// through the single read port starting at the anchor. The next request is
// taken in the cycle after a result is registered.
// Reset (synchronous) sets the word count to min(32, WORDS), the anchor to
// zero and the clean mark to zero, so the whole bitmap reads as zero with no
// clearing pass. A stalled rsp_ch holds its result; the next request then
// waits in the response step until the output register frees up.
module bitmap_free_slot_finder #(
   parameter int WORDS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   bfsf_req_if.sink                   req_ch,
   bfsf_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [bfsf_pkg::CSR_W-1:0] csr_wdata
);
   import bfsf_pkg::*;

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;
   logic [WORD_W-1:0] wu_word;
   logic [OP_W-1:0]   wu_op;
   logic [BIT_W-1:0]  wu_bit;
   wu_res_type        wu_res;

   bfsf_ctrl #(.WORDS(WORDS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .wu_word     (wu_word),
      .wu_op       (wu_op),
      .wu_bit      (wu_bit),
      .wu_res      (wu_res)
   );

   bfsf_mem #(.DEPTH(WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bfsf_word_unit u_word_unit (
      .word    (wu_word),
      .op      (wu_op),
      .bit_pos (wu_bit),
      .res     (wu_res)
   );

endmodule

FILE: sim/tb_bitmap_free_slot_finder.sv
// tb_bitmap_free_slot_finder: self-checking testbench for the bitmap free slot finder,
// with a shadow bitmap predictor, bursty request traffic and a stalling response side
// depends on bfsf_pkg, bfsf_if and the bitmap_free_slot_finder rtl
module tb_bitmap_free_slot_finder;
   timeunit 1ns;
   timeprecision 1ps;
   import bfsf_pkg::*;

   localparam int NWORDS     = 32;
   localparam int SETTLE     = NWORDS + 8;
   localparam int LONG_HOLD  = 300;
   localparam int MAX_PRINTS = 100;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              bit_value;
      logic [IDX_W-1:0]  found_index;
   } slot_result_type;

   class bitmap_shadow;
      logic [WORD_W-1:0] words [NWORDS];
      int                anchor;
      int                count;
      slot_result_type   pending_results [$];
      int                errors;

      function new();
         foreach (words[i]) words[i] = '0;
         anchor = 0;
         count  = NWORDS;
         errors = 0;
      endfunction

      // saturates like the block; words coming back into use are cleared
      function void apply_count(logic [CSR_W-1:0] v);
         int n;
         n = (v > NWORDS) ? NWORDS : int'(v);
         for (int i = count; i < n; i++) words[i] = '0;
         count = n;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
         int                w;
         logic [WORD_W-1:0] m;
         slot_result_type   r;
         bit                hit;
         w   = int'(idx[IDX_W-1:BIT_W]);
         m   = 32'd1 << idx[BIT_W-1:0];
         r   = '0;
         hit = 1'b0;
         r.status = STAT_OK;
         case (op)
            OP_SET: begin
               if (w >= count) begin
                  r.status = STAT_RANGE;
               end else begin
                  words[w] |= m;
                  if (w == anchor && words[w] == FULL_WORD) anchor++;
               end
            end
            OP_UNSET: begin
               if (w >= count) begin
                  r.status = STAT_RANGE;
               end else begin
                  words[w] &= ~m;
                  if (w <= anchor) anchor = w;
               end
            end
            OP_GET: begin
               if (w >= count) r.status = STAT_RANGE;
               else r.bit_value = |(words[w] & m);
            end
            OP_SEARCH: begin
               for (int i = anchor; i < count && !hit; i++) begin
                  for (int j = 0; j < WORD_W && !hit; j++) begin
                     if (!words[i][j]) begin
                        anchor        = i;
                        r.found_index = IDX_W'(i * WORD_W + j);
                        hit           = 1'b1;
                     end
                  end
               end
               if (!hit) r.status = STAT_NONE;
            end
            OP_CLEAR: begin
               for (int i = 0; i < count; i++) words[i] = '0;
               anchor = 0;
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [STAT_W-1:0] status, logic bit_value,
                        logic [IDX_W-1:0] found_index);
         slot_result_type e;
         if (pending_results.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding");
         end else begin
            e = pending_results.pop_front();
            if (status !== e.status)
               report_mismatch($sformatf("status got %0d exp %0d", status, e.status));
            if (bit_value !== e.bit_value)
               report_mismatch($sformatf("bit_value got %0d exp %0d", bit_value, e.bit_value));
            if (found_index !== e.found_index)
               report_mismatch($sformatf("found_index got %0d exp %0d",
                                         found_index, e.found_index));
         end
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;

   bfsf_req_if req_ch ();
   bfsf_rsp_if rsp_ch ();

   bitmap_free_slot_finder #(.WORDS(NWORDS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bitmap_shadow shadow = new();

   int rx_mode      = 0;
   bit hold_pending = 1'b0;
   bit sender_gaps  = 1'b0;
   int burst_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // both channels are sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) shadow.note_request(req_ch.op, req_ch.bit_index);
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_result(rsp_ch.status, rsp_ch.bit_value, rsp_ch.found_index);
      end
   end

   // response side: free running, random stalls or a fixed pattern, plus long holds
   initial begin : rsp_side
      int tick;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         tick++;
         case (rx_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
            default: rsp_ch.ready <= ((tick % 8) > 2);
         endcase
      end
   end

   task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.bit_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (shadow.pending_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_word_count(input logic [CSR_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.apply_count(v);
   endtask

   // set every bit of the anchor word in random order, sometimes one hole; then search
   task automatic fill_anchor_word(output int n);
      int w;
      int order [WORD_W];
      int k, t, tmp;
      bit hole;
      w    = shadow.anchor;
      n    = 0;
      hole = ($urandom_range(0, 3) == 0);
      if (w < shadow.count) begin
         for (k = 0; k < WORD_W; k++) order[k] = k;
         for (k = WORD_W - 1; k > 0; k--) begin
            t        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[t];
            order[t] = tmp;
         end
         for (k = 0; k < WORD_W; k++) begin
            if (k < WORD_W - 1 || !hole) begin
               pace();
               send_op(OP_SET, IDX_W'(w * WORD_W + order[k]));
               n++;
            end
         end
         pace();
         send_op(OP_SEARCH, IDX_W'($urandom_range(0, 1023)));
         n++;
      end
   endtask

   task automatic random_item(output int n);
      int               pick;
      int               wc;
      logic [IDX_W-1:0] idx;
      logic [OP_W-1:0]  op;
      wc = shadow.count;
      if (wc > 0 && $urandom_range(0, 9) != 0) idx = IDX_W'($urandom_range(0, wc * WORD_W - 1));
      else idx = IDX_W'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      n    = 1;
      if (pick < 35) op = OP_SET;
      else if (pick < 47) op = OP_UNSET;
      else if (pick < 62) op = OP_GET;
      else if (pick < 85) op = OP_SEARCH;
      else if (pick < 88) op = OP_CLEAR;
      else begin
         op = OP_W'($urandom_range(5, 7));
         n  = 0;
      end
      pace();
      send_op(op, idx);
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] wc, input int items, input int mode,
                            input bit gaps, input bit long_hold);
      int sent, n;
      bit held;
      write_word_count(wc);
      rx_mode     = mode;
      sender_gaps = gaps;
      sent        = 0;
      held        = 1'b0;
      while (sent < items) begin
         if ($urandom_range(0, 11) == 0) fill_anchor_word(n);
         else random_item(n);
         sent += n;
         if (long_hold && !held && sent >= 20) begin
            hold_pending = 1'b1;
            held         = 1'b1;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_SET;
      req_ch.bit_index = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: word count at its reset value
      rx_mode = 1;
      send_op(OP_GET, 10'd0);
      send_op(OP_SET, 10'd0);
      send_op(OP_GET, 10'd0);
      send_op(OP_SET, 10'd1023);
      send_op(OP_GET, 10'd1023);
      send_op(OP_SEARCH, 10'd0);
      send_op(OP_UNSET, 10'd0);
      send_op(OP_SEARCH, 10'd1023);
      send_op(OP_SET, 10'd31);
      send_op(OP_UNSET, 10'd1023);
      send_op(OP_GET, 10'd1023);
      send_op(OP_W'(5), 10'd1023);
      send_op(OP_W'(6), 10'h2AA);
      send_op(OP_W'(7), 10'h155);
      send_op(OP_SET, 10'd500);
      send_op(OP_CLEAR, 10'd0);
      send_op(OP_GET, 10'd31);
      send_op(OP_SEARCH, 10'd0);
      // shrink to one word: everything past bit 31 is out of range
      write_word_count(6'd1);
      send_op(OP_SET, 10'd32);
      send_op(OP_UNSET, 10'd1023);
      send_op(OP_GET, 10'd40);
      send_op(OP_SEARCH, 10'd0);

      run_phase(6'd1, 70, 0, 1'b0, 1'b0);
      run_phase(6'd0, 30, 1, 1'b1, 1'b0);
      run_phase(6'd2, 70, 2, 1'b1, 1'b1);
      run_phase(6'd4, 70, 1, 1'b1, 1'b0);
      run_phase(6'd63, 70, 0, 1'b1, 1'b0);
      run_phase(6'd2, 70, 1, 1'b0, 1'b0);
      run_phase(6'd33, 70, 2, 1'b1, 1'b1);
      run_phase(CSR_W'($urandom_range(0, 63)), 70, 1, 1'b1, 1'b0);
      run_phase(CSR_W'($urandom_range(0, 63)), 70, 0, 1'b1, 1'b0);
      run_phase(6'd32, 70, 1, 1'b1, 1'b0);

      drain();
      if (shadow.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
